// File: hw/rtl/process_admission_controller_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the job admission controller
// All macros sample on i_clk and are held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PROCESS_ADMISSION_CONTROLLER_CORE_ASSERT_SVH
`define PROCESS_ADMISSION_CONTROLLER_CORE_ASSERT_SVH

// invariant that holds at every edge
`define PAC_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// same-cycle implication
`define PAC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/pac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_pkg
// Shared constants and types of the job admission controller.
// ----------------------------------------------------------------------------
package pac_pkg;

    localparam int SLOTS_DEF       = 16;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 16;
    localparam int MEM_BITS_DEF    = 16;

    localparam int MAX_SLOTS_W = 5;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int STATUS_W    = 3;

    localparam logic [MAX_SLOTS_W-1:0] MAX_SLOTS_RST = 5'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLOTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_CAP   = 2'd1;

    typedef enum logic {
        CMD_CREATE = 1'b0,
        CMD_KILL   = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADMITTED  = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_KILLED    = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_QUEUE_FULL = 3'd4,
        ST_INVALID   = 3'd5
    } t_status;

    // wait queue controls from the sequencer
    typedef struct packed {
        logic rd;    // fetch head entry
        logic push;
        logic pop;
    } t_q_ctl;

endpackage

// File: hw/rtl/pac_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_if
// Request, result and configuration channels (valid/ready).
// ----------------------------------------------------------------------------
interface pac_req_if #(
    parameter int ID_BITS  = pac_pkg::ID_BITS_DEF,
    parameter int MEM_BITS = pac_pkg::MEM_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [ID_BITS-1:0]  prog_id;
    logic [MEM_BITS-1:0] mem_need;

    modport source (output valid, cmd, prog_id, mem_need, input ready);
    modport sink   (input valid, cmd, prog_id, mem_need, output ready);
endinterface

interface pac_res_if #(
    parameter int ID_BITS  = pac_pkg::ID_BITS_DEF,
    parameter int MEM_BITS = pac_pkg::MEM_BITS_DEF,
    parameter int RUN_W    = 5,
    parameter int WAIT_W   = 5
);
    logic                         valid;
    logic                         ready;
    logic [pac_pkg::STATUS_W-1:0] status;
    logic                         woken_valid;
    logic [ID_BITS-1:0]           woken_id;
    logic [MEM_BITS-1:0]          free_memory;
    logic [RUN_W-1:0]             running_count;
    logic [WAIT_W-1:0]            waiting_count;

    modport source (output valid, status, woken_valid, woken_id, free_memory,
                    running_count, waiting_count, input ready);
    modport sink   (input valid, status, woken_valid, woken_id, free_memory,
                    running_count, waiting_count, output ready);
endinterface

interface pac_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pac_pkg::CFG_IDX_W-1:0]  index;
    logic [pac_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/process_admission_controller_core.sv
`timescale 1ns / 1ps
// A request is taken only while idle; a valid one walks every slot, an invalid one skips the walk.
// The walk reads the slot memory one slot a cycle through its single read port before deciding.
// The result register lets the next request start while a result waits.
// Reset (synchronous, active low): slots free, queue empty, max_slots 16,
//   memory capacity and free memory all ones. No clearing pass.
// ----------------------------------------------------------------------------
// process_admission_controller_core
// Job admission with a slot limit, a memory budget and a FIFO wait queue.
// ----------------------------------------------------------------------------
module process_admission_controller_core #(
    parameter int SLOTS       = pac_pkg::SLOTS_DEF,
    parameter int QUEUE_DEPTH = pac_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = pac_pkg::ID_BITS_DEF,
    parameter int MEM_BITS    = pac_pkg::MEM_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pac_req_if.sink    i_req,
    pac_res_if.source  o_res,
    pac_cfg_if.sink    i_cfg
);
    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int WAIT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int CAP_W      = (MEM_BITS < pac_pkg::CFG_DATA_W) ? MEM_BITS
                                                                 : pac_pkg::CFG_DATA_W;
    localparam int LIM_W      = (SLOT_IDX_W > pac_pkg::MAX_SLOTS_W) ? SLOT_IDX_W
                                                                    : pac_pkg::MAX_SLOTS_W;
    localparam int ENTRY_W    = ID_BITS + MEM_BITS;
    localparam logic [MEM_BITS-1:0] MEM_RST = MEM_BITS'((64'd1 << CAP_W) - 64'd1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state                             r_state;
    pac_pkg::t_cmd                      r_cmd;
    logic [ID_BITS-1:0]                 r_id;
    logic [MEM_BITS-1:0]                r_need;
    logic [pac_pkg::MAX_SLOTS_W-1:0]    r_max_slots;
    logic [CAP_W-1:0]                   r_mem_cap;
    logic [SLOTS-1:0]                   r_used;
    logic [CNT_W-1:0]                   r_run_cnt;
    logic [MEM_BITS-1:0]                r_mem_left;
    logic [CNT_W-1:0]                   r_issue_idx;
    logic                               r_chk_vld;
    logic [SLOT_IDX_W-1:0]              r_chk_idx;
    logic                               r_found;
    logic                               r_free_vld;
    logic [SLOT_IDX_W-1:0]              r_free_idx;
    pac_pkg::t_status                   r_status;
    logic                               r_woken_v;
    logic [ID_BITS-1:0]                 r_woken_id;

    logic                               r_o_valid;
    pac_pkg::t_status                   r_o_status;
    logic                               r_o_woken_v;
    logic [ID_BITS-1:0]                 r_o_woken_id;
    logic [MEM_BITS-1:0]                r_o_free;
    logic [CNT_W-1:0]                   r_o_run;
    logic [WAIT_W-1:0]                  r_o_wait;

    logic [ENTRY_W-1:0]                 slot_ram [SLOTS];
    logic [ENTRY_W-1:0]                 r_slot_rd;

    logic                               accept;
    logic                               req_invalid;
    logic                               issue;
    logic                               chk_used;
    logic                               chk_hit;
    logic                               chk_free;
    logic [ID_BITS-1:0]                 chk_job;
    logic [MEM_BITS-1:0]                chk_mem;
    logic [MEM_BITS:0]                  chk_sum;
    logic [MEM_BITS-1:0]                freed_left;
    logic                               occ;
    logic [ID_BITS-1:0]                 occ_id;
    logic [MEM_BITS-1:0]                occ_mem;
    logic                               dec_woken;
    pac_pkg::t_status                   dec_status;
    pac_pkg::t_q_ctl                    q_ctl;
    logic [ID_BITS-1:0]                 q_head_id;
    logic [MEM_BITS-1:0]                q_head_mem;
    logic [WAIT_W-1:0]                  q_count;
    logic                               out_load;
    logic [MEM_BITS-1:0]                n_mem_left;
    logic [CNT_W-1:0]                   n_run_cnt;

    // ---------------------------------------------------------------- handshakes
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign accept      = i_req.valid && i_req.ready;
    assign req_invalid = (&i_req.prog_id) ||
                         ((pac_pkg::t_cmd'(i_req.cmd) == pac_pkg::CMD_CREATE) &&
                          (i_req.mem_need > MEM_BITS'(r_mem_cap)));
    assign out_load    = (r_state == S_DONE) && (!r_o_valid || o_res.ready);

    // ---------------------------------------------------------------- slot walk
    assign issue    = (r_state == S_SCAN) && (r_issue_idx < CNT_W'(SLOTS));
    assign chk_used = r_used[r_chk_idx];
    assign chk_job  = r_slot_rd[ENTRY_W-1:MEM_BITS];
    assign chk_mem  = r_slot_rd[MEM_BITS-1:0];
    assign chk_hit  = r_chk_vld && (r_cmd == pac_pkg::CMD_KILL) && chk_used &&
                      (chk_job == r_id);
    // slot is free after this step and below the admission limit
    assign chk_free = r_chk_vld && (!chk_used || chk_hit) &&
                      (LIM_W'(r_chk_idx) < LIM_W'(r_max_slots));
    assign chk_sum    = {1'b0, r_mem_left} + {1'b0, chk_mem};
    assign freed_left = chk_sum[MEM_BITS] ? '1 : chk_sum[MEM_BITS-1:0];

    // ---------------------------------------------------------------- decision
    always_comb begin
        occ        = 1'b0;
        occ_id     = r_id;
        occ_mem    = r_need;
        dec_woken  = 1'b0;
        dec_status = pac_pkg::ST_INVALID;
        q_ctl.rd   = accept;
        q_ctl.push = 1'b0;
        q_ctl.pop  = 1'b0;
        if (r_state == S_DECIDE) begin
            if (r_cmd == pac_pkg::CMD_CREATE) begin
                if (r_free_vld && (r_mem_left >= r_need)) begin
                    occ        = 1'b1;
                    dec_status = pac_pkg::ST_ADMITTED;
                end else if (q_count < WAIT_W'(QUEUE_DEPTH)) begin
                    q_ctl.push = 1'b1;
                    dec_status = pac_pkg::ST_QUEUED;
                end else begin
                    dec_status = pac_pkg::ST_QUEUE_FULL;
                end
            end else begin
                dec_status = r_found ? pac_pkg::ST_KILLED : pac_pkg::ST_NOT_FOUND;
                if ((q_count != '0) && (q_head_mem <= r_mem_left) && r_free_vld) begin
                    occ       = 1'b1;
                    occ_id    = q_head_id;
                    occ_mem   = q_head_mem;
                    dec_woken = 1'b1;
                    q_ctl.pop = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_mem_left = r_mem_left;
        n_run_cnt  = r_run_cnt;
        if (chk_hit) begin
            n_mem_left = freed_left;
            n_run_cnt  = r_run_cnt - 1'b1;
        end else if (occ) begin
            n_mem_left = r_mem_left - occ_mem;
            n_run_cnt  = r_run_cnt + 1'b1;
        end
    end

    // ---------------------------------------------------------------- slot memory
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_slot_rd <= slot_ram[r_issue_idx[SLOT_IDX_W-1:0]];
        end
        if (occ) begin
            slot_ram[r_free_idx] <= {occ_id, occ_mem};
        end
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_slots <= pac_pkg::MAX_SLOTS_RST;
            r_mem_cap   <= '1;
            r_used      <= '0;
            r_run_cnt   <= '0;
            r_mem_left  <= MEM_RST;
            r_issue_idx <= '0;
            r_chk_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_free_vld  <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == pac_pkg::CFG_MAX_SLOTS) begin
                    r_max_slots <= i_cfg.data[pac_pkg::MAX_SLOTS_W-1:0];
                end else if (i_cfg.index == pac_pkg::CFG_MEM_CAP) begin
                    r_mem_cap <= i_cfg.data[CAP_W-1:0];
                end
            end

            r_mem_left <= n_mem_left;
            r_run_cnt  <= n_run_cnt;
            if (chk_hit) begin
                r_used[r_chk_idx] <= 1'b0;
                r_found           <= 1'b1;
            end
            if (occ) begin
                r_used[r_free_idx] <= 1'b1;
            end
            if (chk_free && !r_free_vld) begin
                r_free_vld <= 1'b1;
            end

            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_issue_idx <= '0;
                        r_chk_vld   <= 1'b0;
                        r_found     <= 1'b0;
                        r_free_vld  <= 1'b0;
                        r_state     <= req_invalid ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (issue) begin
                        r_chk_vld   <= 1'b1;
                        r_issue_idx <= r_issue_idx + 1'b1;
                    end else begin
                        r_chk_vld <= 1'b0;
                        // last read checked: walk is complete
                        if (!r_chk_vld) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= pac_pkg::t_cmd'(i_req.cmd);
            r_id       <= i_req.prog_id;
            r_need     <= i_req.mem_need;
            r_status   <= pac_pkg::ST_INVALID;
            r_woken_v  <= 1'b0;
            r_woken_id <= '0;
        end
        if (issue) begin
            r_chk_idx <= r_issue_idx[SLOT_IDX_W-1:0];
        end
        if (chk_free && !r_free_vld) begin
            r_free_idx <= r_chk_idx;
        end
        if (r_state == S_DECIDE) begin
            r_status   <= dec_status;
            r_woken_v  <= dec_woken;
            r_woken_id <= dec_woken ? q_head_id : '0;
        end
        if (out_load) begin
            r_o_status   <= r_status;
            r_o_woken_v  <= r_woken_v;
            r_o_woken_id <= r_woken_id;
            r_o_free     <= r_mem_left;
            r_o_run      <= r_run_cnt;
            r_o_wait     <= q_count;
        end
    end

    // ---------------------------------------------------------------- wait queue
    pac_wait_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .MEM_BITS    (MEM_BITS),
        .WAIT_W      (WAIT_W)
    ) u_wait_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (q_ctl),
        .i_push_id  (r_id),
        .i_push_mem (r_need),
        .o_head_id  (q_head_id),
        .o_head_mem (q_head_mem),
        .o_count    (q_count)
    );

    // ---------------------------------------------------------------- outputs
    assign o_res.valid         = r_o_valid;
    assign o_res.status        = r_o_status;
    assign o_res.woken_valid   = r_o_woken_v;
    assign o_res.woken_id      = r_o_woken_id;
    assign o_res.free_memory   = r_o_free;
    assign o_res.running_count = r_o_run;
    assign o_res.waiting_count = r_o_wait;

    // ---------------------------------------------------------------- checks
`include "process_admission_controller_core_assert.svh"

    `PAC_ASSERT_ALWAYS(a_run_matches_used, 32'(r_run_cnt) == $countones(r_used),
                       "run count differs from occupied slots")
    `PAC_ASSERT_ALWAYS(a_wait_bound, q_count <= WAIT_W'(QUEUE_DEPTH),
                       "wait queue overfilled")
    `PAC_ASSERT_NEXT(a_accept_starts, i_req.valid && i_req.ready,
                     (r_state == S_SCAN) || (r_state == S_DONE),
                     "request beat did not start work")
    `PAC_ASSERT_IMPL(a_wake_on_kill, o_res.valid && o_res.woken_valid,
                     (o_res.status == pac_pkg::ST_KILLED) ||
                     (o_res.status == pac_pkg::ST_NOT_FOUND),
                     "wake reported on a non-kill beat")

endmodule

// File: hw/rtl/pac_wait_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_wait_queue
// FIFO of waiting jobs (id, memory need) in a synchronous memory.
// ----------------------------------------------------------------------------
module pac_wait_queue #(
    parameter int QUEUE_DEPTH = pac_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = pac_pkg::ID_BITS_DEF,
    parameter int MEM_BITS    = pac_pkg::MEM_BITS_DEF,
    parameter int WAIT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pac_pkg::t_q_ctl     i_ctl,
    input  logic [ID_BITS-1:0]  i_push_id,
    input  logic [MEM_BITS-1:0] i_push_mem,
    output logic [ID_BITS-1:0]  o_head_id,
    output logic [MEM_BITS-1:0] o_head_mem,
    output logic [WAIT_W-1:0]   o_count
);
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int ENTRY_W = ID_BITS + MEM_BITS;

    logic [ENTRY_W-1:0] q_ram [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;
    logic [PTR_W-1:0]   r_head;
    logic [PTR_W-1:0]   r_tail;
    logic [WAIT_W-1:0]  r_count;
    logic [PTR_W-1:0]   n_head;
    logic [PTR_W-1:0]   n_tail;

    always_comb begin
        n_head = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
        n_tail = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            q_ram[r_tail] <= {i_push_id, i_push_mem};
        end
        if (i_ctl.rd) begin
            r_rd_data <= q_ram[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_ctl.push) begin
                r_tail  <= n_tail;
                r_count <= r_count + 1'b1;
            end else if (i_ctl.pop) begin
                r_head  <= n_head;
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head_id  = r_rd_data[ENTRY_W-1:MEM_BITS];
    assign o_head_mem = r_rd_data[MEM_BITS-1:0];
    assign o_count    = r_count;

endmodule

// File: sim/admission_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// admission_checker
// Watches the request, result and config channels of the admission
// controller, keeps its own copy of slots, wait queue and budget, and checks
// every result beat against the outcome predicted for the oldest request.
// ----------------------------------------------------------------------------
module admission_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    pac_req_if   i_req,
    pac_res_if   i_res,
    pac_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    localparam int NSLOT  = pac_pkg::SLOTS_DEF;
    localparam int QDEPTH = pac_pkg::QUEUE_DEPTH_DEF;
    localparam int ID_W   = pac_pkg::ID_BITS_DEF;
    localparam int MEM_W  = pac_pkg::MEM_BITS_DEF;
    localparam logic [ID_W-1:0]  ID_INVALID = '1;
    localparam logic [MEM_W-1:0] MEM_FULL   = '1;

    typedef struct packed {
        pac_pkg::t_status status;
        logic             woken_valid;
        logic [ID_W-1:0]  woken_id;
        logic [MEM_W-1:0] free_memory;
        logic [4:0]       running_count;
        logic [4:0]       waiting_count;
    } t_outcome;

    // predictor state
    logic [4:0]       max_slots;
    logic [MEM_W-1:0] mem_cap;
    logic             slot_busy [NSLOT];
    logic [ID_W-1:0]  slot_id   [NSLOT];
    logic [MEM_W-1:0] slot_need [NSLOT];
    logic [ID_W-1:0]  q_id      [QDEPTH];
    logic [MEM_W-1:0] q_need    [QDEPTH];
    int               q_head;
    int               q_tail;
    int               q_cnt;
    int               run_cnt;
    logic [MEM_W-1:0] mem_free;

    t_outcome outcome_q[$];
    int       err_cnt = 0;

    function automatic int lowest_free_slot();
        int lim;
        lim = (max_slots < NSLOT) ? int'(max_slots) : NSLOT;
        for (int k = 0; k < lim; k++) begin
            if (!slot_busy[k]) return k;
        end
        return -1;
    endfunction

    function automatic void occupy(int k, logic [ID_W-1:0] id, logic [MEM_W-1:0] need);
        slot_busy[k] = 1'b1;
        slot_id[k]   = id;
        slot_need[k] = need;
        mem_free     = mem_free - need;
        run_cnt++;
    endfunction

    function automatic t_outcome admit_step(pac_pkg::t_cmd c, logic [ID_W-1:0] id,
                                            logic [MEM_W-1:0] need);
        t_outcome       o;
        int             k;
        logic           hit;
        logic [MEM_W:0] sum;
        o = '0;
        if (id == ID_INVALID) begin
            o.status = pac_pkg::ST_INVALID;
        end else if (c == pac_pkg::CMD_CREATE) begin
            if (need > mem_cap) begin
                o.status = pac_pkg::ST_INVALID;
            end else begin
                k = lowest_free_slot();
                if (k >= 0 && mem_free >= need) begin
                    occupy(k, id, need);
                    o.status = pac_pkg::ST_ADMITTED;
                end else if (q_cnt < QDEPTH) begin
                    q_id[q_tail]   = id;
                    q_need[q_tail] = need;
                    q_tail = (q_tail + 1) % QDEPTH;
                    q_cnt++;
                    o.status = pac_pkg::ST_QUEUED;
                end else begin
                    o.status = pac_pkg::ST_QUEUE_FULL;
                end
            end
        end else begin
            // kill walks every slot, also those above a lowered limit
            hit = 1'b0;
            for (int s = 0; s < NSLOT; s++) begin
                if (slot_busy[s] && slot_id[s] == id) begin
                    sum          = {1'b0, mem_free} + slot_need[s];
                    slot_busy[s] = 1'b0;
                    run_cnt--;
                    mem_free = sum[MEM_W] ? MEM_FULL : sum[MEM_W-1:0];
                    hit      = 1'b1;
                end
            end
            o.status = hit ? pac_pkg::ST_KILLED : pac_pkg::ST_NOT_FOUND;
            if (q_cnt > 0 && q_need[q_head] <= mem_free) begin
                k = lowest_free_slot();
                if (k >= 0) begin
                    o.woken_valid = 1'b1;
                    o.woken_id    = q_id[q_head];
                    occupy(k, q_id[q_head], q_need[q_head]);
                    q_head = (q_head + 1) % QDEPTH;
                    q_cnt--;
                end
            end
        end
        o.free_memory   = mem_free;
        o.running_count = 5'(run_cnt);
        o.waiting_count = 5'(q_cnt);
        return o;
    endfunction

    always @(posedge i_clk) begin : watch
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            max_slots = pac_pkg::MAX_SLOTS_RST;
            mem_cap   = MEM_FULL;
            mem_free  = MEM_FULL;
            for (int k = 0; k < NSLOT; k++) slot_busy[k] = 1'b0;
            q_head  = 0;
            q_tail  = 0;
            q_cnt   = 0;
            run_cnt = 0;
            outcome_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == pac_pkg::CFG_MAX_SLOTS) max_slots = i_cfg.data[4:0];
                else if (i_cfg.index == pac_pkg::CFG_MEM_CAP) mem_cap = i_cfg.data;
            end
            if (i_res.valid && i_res.ready) begin
                got.status        = pac_pkg::t_status'(i_res.status);
                got.woken_valid   = i_res.woken_valid;
                got.woken_id      = i_res.woken_id;
                got.free_memory   = i_res.free_memory;
                got.running_count = i_res.running_count;
                got.waiting_count = i_res.waiting_count;
                if (outcome_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result beat: expected none, actual st=%0d",
                             $time, got.status);
                end else begin
                    want = outcome_q.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        $display("%0t: mismatch expected st=%0d wk=%0b/%h free=%0d run=%0d wait=%0d",
                                 $time, want.status, want.woken_valid, want.woken_id,
                                 want.free_memory, want.running_count, want.waiting_count);
                        $display("%0t:          actual   st=%0d wk=%0b/%h free=%0d run=%0d wait=%0d",
                                 $time, got.status, got.woken_valid, got.woken_id,
                                 got.free_memory, got.running_count, got.waiting_count);
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                outcome_q.push_back(admit_step(pac_pkg::t_cmd'(i_req.cmd), i_req.prog_id,
                                               i_req.mem_need));
            end
            o_pending <= outcome_q.size();
        end
        o_fail_count <= err_cnt;
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives job requests and register writes into the admission controller in
// phases of different slot limits and budgets, with bursty requests and a
// stalling result side; the checker beside the block does all comparing.
// ----------------------------------------------------------------------------
module testbench;
    localparam logic [pac_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [pac_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam logic [15:0] ID_INVALID = 16'hFFFF;
    localparam int          SETTLE     = pac_pkg::SLOTS_DEF + 8;
    localparam int          LONG_HOLD  = 400;

    logic i_clk;
    logic i_rst_n;
    logic long_hold;
    int   fail_count;
    int   pending;
    int   burst_left;
    logic [15:0] cur_cap;

    pac_req_if req_ch ();
    pac_res_if res_ch ();
    pac_cfg_if cfg_ch ();

    process_admission_controller_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    admission_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // result side: stretches of random duty, plus one long hold on request
    initial begin : receiver
        int   stretch;
        int   duty;
        logic held;
        held = 1'b0;
        res_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold && !held) begin
                held = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                stretch = $urandom_range(4, 60);
                duty    = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(10, 90);
                repeat (stretch) begin
                    res_ch.ready <= ($urandom_range(0, 99) < duty);
                    @(posedge i_clk);
                end
            end
        end
    end

    task automatic push_req(input pac_pkg::t_cmd c, input logic [15:0] id,
                            input logic [15:0] need);
        int gap;
        req_ch.valid    <= 1'b1;
        req_ch.cmd      <= c;
        req_ch.prog_id  <= id;
        req_ch.mem_need <= need;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(1, 30);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [pac_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // let every outstanding result out, then give the block time to settle
    task automatic drain();
        if (req_ch.valid) req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [4:0] slots, input logic [15:0] cap,
                             input int n, input int pool, input int need_max,
                             input int hold_at);
        logic [15:0]   base;
        logic [15:0]   id;
        logic [15:0]   need;
        pac_pkg::t_cmd c;
        int            r;
        drain();
        write_reg(pac_pkg::CFG_MAX_SLOTS, {11'($urandom), slots});
        write_reg(pac_pkg::CFG_MEM_CAP, cap);
        write_reg(CFG_SPARE_LO, 16'($urandom));
        write_reg(CFG_SPARE_HI, 16'($urandom));
        cur_cap = cap;
        base    = 16'($urandom_range(0, 16'hFF00));
        for (int i = 0; i < n; i++) begin
            if (i == hold_at) long_hold <= 1'b1;
            r    = $urandom_range(0, 99);
            c    = pac_pkg::CMD_CREATE;
            id   = base + 16'($urandom_range(0, pool - 1));
            need = 16'($urandom_range(0, need_max));
            if (r < 6) begin
                c    = pac_pkg::t_cmd'($urandom_range(0, 1));
                id   = 16'($urandom);
                need = 16'($urandom);
            end else if (r < 9) begin
                c  = pac_pkg::t_cmd'($urandom_range(0, 1));
                id = ID_INVALID;
            end else if (r < 12 && cur_cap != 16'hFFFF) begin
                need = 16'($urandom_range(int'(cur_cap) + 1, 65535));
            end else if (r >= 55) begin
                c = pac_pkg::CMD_KILL;
            end
            push_req(c, id, need);
        end
    endtask

    initial begin : stimulus
        long_hold       <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.cmd      <= pac_pkg::CMD_CREATE;
        req_ch.prog_id  <= '0;
        req_ch.mem_need <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= pac_pkg::CFG_MAX_SLOTS;
        cfg_ch.data     <= '0;
        burst_left = $urandom_range(1, 20);
        cur_cap    = 16'hFFFF;
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, at reset settings
        push_req(pac_pkg::CMD_CREATE, 16'h0000, 16'h0000);
        push_req(pac_pkg::CMD_CREATE, 16'hFFFE, 16'hFFFF);   // takes the whole budget
        push_req(pac_pkg::CMD_CREATE, 16'h0005, 16'h0001);   // no memory left: queued
        push_req(pac_pkg::CMD_CREATE, ID_INVALID, 16'h0005);
        push_req(pac_pkg::CMD_KILL,   ID_INVALID, 16'h0000);
        push_req(pac_pkg::CMD_KILL,   16'h1234, 16'h0000);   // no match, head does not fit
        push_req(pac_pkg::CMD_KILL,   16'hFFFE, 16'h0000);   // frees budget, wakes head
        push_req(pac_pkg::CMD_CREATE, 16'h0007, 16'hFFFF);
        push_req(pac_pkg::CMD_KILL,   16'h0000, 16'h0000);
        push_req(pac_pkg::CMD_KILL,   16'h0005, 16'h0000);   // wakes the large job
        push_req(pac_pkg::CMD_KILL,   16'h0007, 16'h0000);
        push_req(pac_pkg::CMD_CREATE, 16'h8009, 16'h0064);
        push_req(pac_pkg::CMD_CREATE, 16'h8009, 16'h0064);
        push_req(pac_pkg::CMD_KILL,   16'h8009, 16'h0000);   // duplicate id: both slots go
        push_req(pac_pkg::CMD_KILL,   16'h4242, 16'h0000);

        run_phase(5'd4,  16'd60000, 120, 12, 20000, -1);
        run_phase(5'd0,  16'd1000,   40,  8,  1000, -1);   // no slot admits: creates queue or find the queue full
        run_phase(5'd1,  16'd0,      50,  6,     0, -1);
        run_phase(5'd31, 16'hFFFF,  150, 16, 12000, 40);   // limit above slot count
        run_phase(5'd8,  16'd30000, 150, 10,  8000, -1);
        run_phase(5'd16, 16'hFFFF,  150, 20, 30000, -1);

        drain();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/pac_pkg.sv
hw/rtl/pac_if.sv
hw/rtl/pac_wait_queue.sv
hw/rtl/process_admission_controller_core.sv
sim/admission_checker.sv
sim/testbench.sv
